// ===== hw/rtl/linked_deque_manager_core_defines.svh =====
// ---------------------------------------------------------------------------
// Linked deque manager assertion macros
// Shared property forms for the deque manager checks. They sample on clk and
// are disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef LINKED_DEQUE_MANAGER_CORE_DEFINES_SVH
`define LINKED_DEQUE_MANAGER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LDQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque manager check failed");

// The consequent must hold in the cycle after the antecedent.
`define LDQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque manager check failed");

`endif

// ===== hw/rtl/ldq_pkg.sv =====
// ---------------------------------------------------------------------------
// Linked deque manager package
// Pool size, field widths, action and status codes, and channel item types.
// ---------------------------------------------------------------------------
package ldq_pkg;

  localparam int NODE_COUNT = 256;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int LINK_W     = NODE_W + 1;
  localparam int CNT_W      = 9;

  localparam logic [LINK_W-1:0] NULL_NODE = LINK_W'(NODE_COUNT);

  localparam logic [2:0] ACT_PUSH_BACK  = 3'd0;
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_DETACH     = 3'd4;
  localparam logic [2:0] ACT_RESTART    = 3'd5;
  localparam logic [2:0] ACT_STEP       = 3'd6;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_EMPTY      = 2'd1;
  localparam logic [1:0] ST_LINKED     = 2'd2;
  localparam logic [1:0] ST_NOT_LINKED = 2'd3;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] node_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] result_node;
    logic       result_valid;
    logic [8:0] node_count;
    logic [1:0] status;
  } out_item_t;

  // Handshake between the top level and the engine.
  typedef struct packed {
    logic start;
    logic out_free;
  } eng_ctrl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } eng_stat_t;

  function automatic logic is_node(input logic [LINK_W-1:0] n);
    return n < LINK_W'(NODE_COUNT);
  endfunction

endpackage

// ===== hw/rtl/ldq_link_ram.sv =====
// ---------------------------------------------------------------------------
// Link RAM
// Single write port, single read port memory with a registered read.
// ---------------------------------------------------------------------------
module ldq_link_ram #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 9,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/ldq_engine.sv =====
// ---------------------------------------------------------------------------
// Linked deque engine
// Holds front, back, count, cursor and membership bits, and runs each action
// as a link read followed by a link write-back.
// ---------------------------------------------------------------------------
module ldq_engine
  import ldq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  eng_ctrl_t ctrl,
  input  in_item_t  in_item,
  input  logic      back_to_front,
  output eng_stat_t stat,
  output out_item_t result
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                  state_r, state_nxt;
  logic [2:0]            act_r;
  logic [NODE_W-1:0]     node_r;
  logic [LINK_W-1:0]     tgt_r;
  logic [LINK_W-1:0]     front_r, front_nxt;
  logic [LINK_W-1:0]     back_r, back_nxt;
  logic [LINK_W-1:0]     cursor_r, cursor_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [NODE_COUNT-1:0] linked_r;

  logic                  linked_set, linked_clr;
  logic [NODE_W-1:0]     linked_idx;

  logic [LINK_W-1:0]     tgt_sel;
  logic [LINK_W-1:0]     tb_q, tf_q, eff_tb, eff_tf;
  logic                  tb_we, tf_we;
  logic [NODE_W-1:0]     tb_waddr, tf_waddr;
  logic [LINK_W-1:0]     tb_wdata, tf_wdata;
  logic [LINK_W-1:0]     res;
  logic [1:0]            status;
  logic                  commit;
  logic                  tgt_linked;

  // Node to look up, chosen from the incoming item.
  always_comb begin
    unique case (in_item.action)
      ACT_POP_FRONT: tgt_sel = front_r;
      ACT_POP_BACK:  tgt_sel = back_r;
      ACT_STEP:      tgt_sel = cursor_r;
      default:       tgt_sel = {1'b0, in_item.node_index};
    endcase
  end

  ldq_link_ram #(.DEPTH(NODE_COUNT), .WIDTH(LINK_W)) u_tb_ram (
    .clk     (clk),
    .we      (tb_we),
    .wr_addr (tb_waddr),
    .wr_data (tb_wdata),
    .rd_en   (ctrl.start),
    .rd_addr (tgt_sel[NODE_W-1:0]),
    .rd_data (tb_q)
  );

  ldq_link_ram #(.DEPTH(NODE_COUNT), .WIDTH(LINK_W)) u_tf_ram (
    .clk     (clk),
    .we      (tf_we),
    .wr_addr (tf_waddr),
    .wr_data (tf_wdata),
    .rd_en   (ctrl.start),
    .rd_addr (tgt_sel[NODE_W-1:0]),
    .rd_data (tf_q)
  );

  // The back node's toward-back link and the front node's toward-front link
  // are never written on push; they are null by position, so mask them here.
  assign eff_tb     = (tgt_r == back_r)  ? NULL_NODE : tb_q;
  assign eff_tf     = (tgt_r == front_r) ? NULL_NODE : tf_q;
  assign tgt_linked = linked_r[tgt_r[NODE_W-1:0]];
  assign commit     = (state_r == S_EXEC) && ctrl.out_free;

  always_comb begin
    front_nxt  = front_r;
    back_nxt   = back_r;
    cursor_nxt = cursor_r;
    count_nxt  = count_r;
    linked_set = 1'b0;
    linked_clr = 1'b0;
    linked_idx = node_r;
    tb_we      = 1'b0;
    tf_we      = 1'b0;
    tb_waddr   = node_r;
    tf_waddr   = node_r;
    tb_wdata   = NULL_NODE;
    tf_wdata   = NULL_NODE;
    res        = NULL_NODE;
    status     = ST_OK;
    unique case (act_r)
      ACT_PUSH_BACK: begin
        if (linked_r[node_r]) begin
          status = ST_LINKED;
        end else begin
          tf_we    = 1'b1;
          tf_waddr = node_r;
          tf_wdata = back_r;
          if (is_node(back_r)) begin
            tb_we    = 1'b1;
            tb_waddr = back_r[NODE_W-1:0];
            tb_wdata = {1'b0, node_r};
          end else begin
            front_nxt = {1'b0, node_r};
          end
          back_nxt   = {1'b0, node_r};
          linked_set = 1'b1;
          count_nxt  = count_r + 1'b1;
        end
      end
      ACT_PUSH_FRONT: begin
        if (linked_r[node_r]) begin
          status = ST_LINKED;
        end else begin
          tb_we    = 1'b1;
          tb_waddr = node_r;
          tb_wdata = front_r;
          if (is_node(front_r)) begin
            tf_we    = 1'b1;
            tf_waddr = front_r[NODE_W-1:0];
            tf_wdata = {1'b0, node_r};
          end else begin
            back_nxt = {1'b0, node_r};
          end
          front_nxt  = {1'b0, node_r};
          linked_set = 1'b1;
          count_nxt  = count_r + 1'b1;
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK, ACT_DETACH: begin
        if (count_r == '0 || !is_node(front_r) || !is_node(back_r)) begin
          status = ST_EMPTY;
        end else if (!is_node(tgt_r) || !tgt_linked) begin
          status = ST_NOT_LINKED;
        end else begin
          if (tgt_r == front_r && tgt_r == back_r) begin
            front_nxt = NULL_NODE;
            back_nxt  = NULL_NODE;
          end else if (tgt_r == front_r) begin
            front_nxt = eff_tb;
          end else if (tgt_r == back_r) begin
            back_nxt = eff_tf;
          end
          if (is_node(eff_tb)) begin
            tf_we    = 1'b1;
            tf_waddr = eff_tb[NODE_W-1:0];
            tf_wdata = eff_tf;
          end
          if (is_node(eff_tf)) begin
            tb_we    = 1'b1;
            tb_waddr = eff_tf[NODE_W-1:0];
            tb_wdata = eff_tb;
          end
          linked_clr = 1'b1;
          linked_idx = tgt_r[NODE_W-1:0];
          count_nxt  = count_r - 1'b1;
          res        = tgt_r;
        end
      end
      ACT_RESTART: begin
        cursor_nxt = back_to_front ? back_r : front_r;
      end
      ACT_STEP: begin
        if (is_node(cursor_r)) begin
          res = cursor_r;
          // A node that has left the deque ends the traversal.
          if (!tgt_linked) begin
            cursor_nxt = NULL_NODE;
          end else begin
            cursor_nxt = back_to_front ? eff_tf : eff_tb;
          end
        end
      end
      default: begin
      end
    endcase
    if (!commit) begin
      tb_we = 1'b0;
      tf_we = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (ctrl.start) state_nxt = S_EXEC;
      S_EXEC: if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      front_r  <= NULL_NODE;
      back_r   <= NULL_NODE;
      cursor_r <= NULL_NODE;
      count_r  <= '0;
      linked_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        front_r  <= front_nxt;
        back_r   <= back_nxt;
        cursor_r <= cursor_nxt;
        count_r  <= count_nxt;
        if (linked_set) begin
          linked_r[linked_idx] <= 1'b1;
        end else if (linked_clr) begin
          linked_r[linked_idx] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      act_r  <= in_item.action;
      node_r <= in_item.node_index;
      tgt_r  <= tgt_sel;
    end
  end

  assign stat.idle           = (state_r == S_IDLE);
  assign stat.done           = commit;
  assign result.result_node  = is_node(res) ? res[NODE_W-1:0] : '0;
  assign result.result_valid = is_node(res);
  assign result.node_count   = count_nxt;
  assign result.status       = status;

endmodule

// ===== hw/rtl/linked_deque_manager_core.sv =====
// ---------------------------------------------------------------------------
// Linked deque manager core
// Doubly linked deque over a fixed node pool with front/back push and pop,
// detach of any linked node, and a cursor for traversal.
// ---------------------------------------------------------------------------
// Usage:
// Each item on the in_ channel is one action on the deque (push back, push
// front, pop front, pop back, detach, traversal restart, traversal step).
// Every item yields exactly one result item on the out_ channel carrying
// the node popped, detached or stepped over, the node count after the
// action, and a status code.
// The cfg_ port writes the traversal direction; write it only
// while no item is in flight.
// An item runs as a read and then a write-back: the accept edge reads the two
// link RAMs, and the commit edge, which waits until the output register is
// free, writes them back and loads the output register. A new item is taken
// only once the last one has committed; the read-then-write on the RAMs sets this.
// Reset empties the deque, nulls the cursor and clears the direction; the
// link RAMs are not cleared and need no clearing pass.
// When the receiver stalls, one finished result waits in the output register
// while the next item is accepted; that item then holds in the engine until
// the register frees.
// ---------------------------------------------------------------------------
`include "linked_deque_manager_core_defines.svh"

module linked_deque_manager_core
  import ldq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  logic      dir_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  eng_ctrl_t ctrl;
  eng_stat_t stat;
  out_item_t eng_result;

  assign in_ready      = stat.idle;
  assign ctrl.start    = in_valid && stat.idle;
  assign ctrl.out_free = !out_valid_r || out_ready;

  ldq_engine u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .in_item       (in_item),
    .back_to_front (dir_r),
    .stat          (stat),
    .result        (eng_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        dir_r <= cfg_wdata;
      end
      if (stat.done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      out_item_r <= eng_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `LDQ_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `LDQ_ASSERT_SAME(a_null_result_zero, out_valid && !out_item.result_valid,
                   out_item.result_node == 8'd0)
  `LDQ_ASSERT_SAME(a_count_in_range, out_valid,
                   out_item.node_count <= CNT_W'(NODE_COUNT))
  `LDQ_ASSERT_SAME(a_error_no_result, out_valid && out_item.status != ST_OK,
                   !out_item.result_valid)

endmodule
